>>> rtl/core/tli_pkg.sv
`timescale 1ns / 1ps
package tli_pkg;

  localparam int DW = 32;
  localparam int QW = 33;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_RATIO  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [DW-1:0] RATIO_RESET  = 32'h0001_0000;
  localparam logic [DW-1:0] OFFSET_RESET = 32'h0000_0000;

  typedef struct packed {
    logic       valid;
    logic       is_eval;
    logic [1:0] status;
  } ctl_t;

  function automatic logic signed [DW-1:0] sat_q(input logic signed [65:0] v);
    logic signed [DW-1:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[DW-1:0];
    return r;
  endfunction

endpackage

>>> rtl/core/tli_scale.sv
`timescale 1ns / 1ps
module tli_scale #(
  parameter int CW = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  tli_pkg::ctl_t                ctl_i,
  input  logic signed [tli_pkg::DW-1:0] sample_i,
  input  logic [CW-1:0]                cnt_i,
  input  logic signed [tli_pkg::DW-1:0] ratio_i,
  input  logic signed [tli_pkg::DW-1:0] offset_i,
  output tli_pkg::ctl_t                ctl_o,
  output logic signed [tli_pkg::DW-1:0] v_o,
  output logic [CW-1:0]                cnt_o
);

  tli_pkg::ctl_t        ctl_a_r, ctl_b_r;
  logic signed [63:0]   prod_a_r;
  logic [CW-1:0]        cnt_a_r, cnt_b_r;
  logic signed [tli_pkg::DW-1:0] v_b_r;
  logic signed [63:0]   sh;
  logic signed [65:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
    end
  end

  // floor shift: arithmetic shift rounds toward minus infinity
  always_comb begin
    sh  = prod_a_r >>> 16;
    sum = 66'(sh) + 66'(offset_i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= 64'(sample_i) * 64'(ratio_i);
      cnt_a_r  <= cnt_i;
      v_b_r    <= tli_pkg::sat_q(sum);
      cnt_b_r  <= cnt_a_r;
    end
  end

  assign ctl_o = ctl_b_r;
  assign v_o   = v_b_r;
  assign cnt_o = cnt_b_r;

endmodule

>>> rtl/core/tli_table.sv
`timescale 1ns / 1ps
module tli_table #(
  parameter int MAX_POINTS = 16,
  parameter int CW = 5,
  parameter int IW = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         wr_en,
  input  logic signed [tli_pkg::DW-1:0] wr_x,
  input  logic signed [tli_pkg::DW-1:0] wr_y,
  output logic [CW-1:0]                cnt_o,
  output logic                         full_o,
  input  tli_pkg::ctl_t                ctl_i,
  input  logic signed [tli_pkg::DW-1:0] v_i,
  input  logic [CW-1:0]                cnt_i,
  output tli_pkg::ctl_t                ctl_o,
  output logic                         dir_o,
  output logic signed [tli_pkg::DW-1:0] v_o,
  output logic signed [tli_pkg::DW-1:0] xa_o,
  output logic signed [tli_pkg::DW-1:0] xb_o,
  output logic signed [tli_pkg::DW-1:0] ya_o,
  output logic signed [tli_pkg::DW-1:0] yb_o
);

  logic signed [tli_pkg::DW-1:0] x_r [MAX_POINTS];
  logic signed [tli_pkg::DW-1:0] y_r [MAX_POINTS];
  logic [CW-1:0]                 cnt_r;

  tli_pkg::ctl_t                 ctl_c_r, ctl_d_r;
  logic [MAX_POINTS-1:0]         hit_c_r;
  logic                          eq_c_r;
  logic signed [tli_pkg::DW-1:0] v_c_r, v_d_r;
  logic [CW-1:0]                 cnt_c_r;
  logic                          dir_d_r;
  logic signed [tli_pkg::DW-1:0] xa_d_r, xb_d_r, ya_d_r, yb_d_r;

  logic [IW-1:0]                 last_c, last_d, idx, idx_m1;
  logic                          rising, found;
  logic [MAX_POINTS-1:0]         hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (wr_en) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_r[cnt_r[IW-1:0]] <= wr_x;
      y_r[cnt_r[IW-1:0]] <= wr_y;
    end
  end

  assign cnt_o  = cnt_r;
  assign full_o = (cnt_r == CW'(MAX_POINTS));

  // compare against every entry in parallel
  always_comb begin
    last_c = IW'(cnt_i - 1'b1);
    rising = x_r[last_c] > x_r[0];
    for (int i = 0; i < MAX_POINTS; i++) begin
      hit[i] = (CW'(i) < cnt_i) && (rising ? (x_r[i] > v_i) : (x_r[i] < v_i));
    end
  end

  // first hit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (hit_c_r[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
    idx_m1 = idx - 1'b1;
    last_d = IW'(cnt_c_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else if (en) begin
      ctl_c_r <= ctl_i;
      ctl_d_r <= ctl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_c_r <= hit;
      eq_c_r  <= (x_r[last_c] == x_r[0]);
      v_c_r   <= v_i;
      cnt_c_r <= cnt_i;
      v_d_r   <= v_c_r;
      dir_d_r <= eq_c_r || !found || (idx == '0);
      xa_d_r  <= x_r[idx_m1];
      xb_d_r  <= x_r[idx];
      yb_d_r  <= y_r[idx];
      if (eq_c_r || (found && idx == '0)) ya_d_r <= y_r[0];
      else if (!found) ya_d_r <= y_r[last_d];
      else ya_d_r <= y_r[idx_m1];
    end
  end

  assign ctl_o = ctl_d_r;
  assign dir_o = dir_d_r;
  assign v_o   = v_d_r;
  assign xa_o  = xa_d_r;
  assign xb_o  = xb_d_r;
  assign ya_o  = ya_d_r;
  assign yb_o  = yb_d_r;

endmodule

>>> rtl/core/tli_lerp.sv
`timescale 1ns / 1ps
module tli_lerp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  tli_pkg::ctl_t                ctl_i,
  input  logic                         dir_i,
  input  logic signed [tli_pkg::DW-1:0] v_i,
  input  logic signed [tli_pkg::DW-1:0] xa_i,
  input  logic signed [tli_pkg::DW-1:0] xb_i,
  input  logic signed [tli_pkg::DW-1:0] ya_i,
  input  logic signed [tli_pkg::DW-1:0] yb_i,
  output tli_pkg::ctl_t                ctl_o,
  output logic signed [tli_pkg::DW-1:0] res_o
);

  localparam int QW = tli_pkg::QW;

  tli_pkg::ctl_t                 ctl_e_r, out_ctl_r;
  logic                          dir_e_r, neg_e_r;
  logic signed [tli_pkg::DW-1:0] ya_e_r, res_r;
  logic [QW-1:0]                 ady_e_r, num_e_r, den_e_r;

  tli_pkg::ctl_t                 p_ctl_r [QW+1];
  logic                          p_dir_r [QW+1];
  logic                          p_neg_r [QW+1];
  logic signed [tli_pkg::DW-1:0] p_ya_r  [QW+1];
  logic [QW-1:0]                 p_den_r [QW+1];
  logic [2*QW-1:0]               p_rem_r [QW+1];
  logic [QW-1:0]                 p_q_r   [QW+1];

  logic signed [QW-1:0]          dn, dd, ddy;
  logic signed [QW+1:0]          sum;

  always_comb begin
    dn  = QW'(v_i) - QW'(xa_i);
    dd  = QW'(xb_i) - QW'(xa_i);
    ddy = QW'(yb_i) - QW'(ya_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r    <= '0;
      p_ctl_r[0] <= '0;
    end else if (en) begin
      ctl_e_r    <= ctl_i;
      p_ctl_r[0] <= ctl_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_e_r    <= dir_i;
      ya_e_r     <= ya_i;
      neg_e_r    <= ddy[QW-1];
      ady_e_r    <= ddy[QW-1] ? QW'(-ddy) : QW'(ddy);
      num_e_r    <= dn[QW-1] ? QW'(-dn) : QW'(dn);
      den_e_r    <= dd[QW-1] ? QW'(-dd) : QW'(dd);
      p_dir_r[0] <= dir_e_r;
      p_neg_r[0] <= neg_e_r;
      p_ya_r[0]  <= ya_e_r;
      p_den_r[0] <= den_e_r;
      p_rem_r[0] <= (2*QW)'(ady_e_r) * (2*QW)'(num_e_r);
      p_q_r[0]   <= '0;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [2*QW:0] trial;
    assign trial = {1'b0, p_rem_r[k]} - ((2*QW+1)'(p_den_r[k]) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_ctl_r[k+1] <= '0;
      end else if (en) begin
        p_ctl_r[k+1] <= p_ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_dir_r[k+1] <= p_dir_r[k];
        p_neg_r[k+1] <= p_neg_r[k];
        p_ya_r[k+1]  <= p_ya_r[k];
        p_den_r[k+1] <= p_den_r[k];
        if (!trial[2*QW]) begin
          p_rem_r[k+1] <= trial[2*QW-1:0];
          p_q_r[k+1]   <= p_q_r[k] | (QW'(1) << B);
        end else begin
          p_rem_r[k+1] <= p_rem_r[k];
          p_q_r[k+1]   <= p_q_r[k];
        end
      end
    end
  end

  always_comb begin
    if (p_neg_r[QW]) sum = (QW+2)'(p_ya_r[QW]) - (QW+2)'({1'b0, p_q_r[QW]});
    else             sum = (QW+2)'(p_ya_r[QW]) + (QW+2)'({1'b0, p_q_r[QW]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else if (en) begin
      out_ctl_r <= p_ctl_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!p_ctl_r[QW].is_eval) res_r <= '0;
      else if (p_dir_r[QW]) res_r <= p_ya_r[QW];
      else res_r <= tli_pkg::sat_q(66'(sum));
    end
  end

  assign ctl_o = out_ctl_r;
  assign res_o = res_r;

endmodule

>>> rtl/core/table_linear_interpolator.sv
`timescale 1ns / 1ps
// Piecewise linear lookup over a table of up to MAX_POINTS breakpoints.
// Input channel (in_valid / in_stall): opcode 0 appends (point_in, point_out)
// to the table, opcode 1 evaluates sample. Every input beat gives exactly one
// output beat (out_valid / out_stall) carrying result_value and status, in
// input order. Loads write the table at acceptance, so a following evaluate
// sees them at once.
// Scaling by scale_ratio / scale_offset is set through the APB port at
// byte addresses 0 and 4; write it only while the pipeline is empty.
// From acceptance to out_valid a beat passes two scaling stages, two
// table stages (parallel compare, then first-hit select and fetch), a
// difference stage, a multiply stage, a 33-stage bit-per-stage divider and
// the output register. A beat is accepted every cycle that in_stall is low.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated.
// Reset empties the table, clears all valid bits and restores ratio 1.0 and
// offset 0.
module table_linear_interpolator #(
  parameter int MAX_POINTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [31:0]           in_point_in,
  input  logic signed [31:0]           in_point_out,
  input  logic signed [31:0]           in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_result_value,
  output logic [1:0]                   out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);

  logic signed [31:0] ratio_r, offset_r;
  logic               en, acc, wr_en, full, empty;
  logic [CW-1:0]      cnt;
  tli_pkg::ctl_t      ctl_in, ctl_s, ctl_t2, ctl_out;
  logic signed [31:0] v_s, v_t, xa, xb, ya, yb, res;
  logic [CW-1:0]      cnt_s;
  logic               dir_t;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= tli_pkg::RATIO_RESET;
      offset_r <= tli_pkg::OFFSET_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tli_pkg::REG_RATIO:  ratio_r  <= pwdata;
        tli_pkg::REG_OFFSET: offset_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tli_pkg::REG_RATIO:  prdata = ratio_r;
      tli_pkg::REG_OFFSET: prdata = offset_r;
      default:             prdata = '0;
    endcase
  end

  // hold everything while a result waits on a stalled receiver
  assign en       = !(ctl_out.valid && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;
  assign empty    = (cnt == '0);
  assign wr_en    = acc && (in_opcode == tli_pkg::OP_LOAD) && !full;

  always_comb begin
    ctl_in.valid   = in_valid;
    ctl_in.is_eval = (in_opcode == tli_pkg::OP_EVAL) && !empty;
    if (in_opcode == tli_pkg::OP_LOAD) ctl_in.status = full ? tli_pkg::ST_FULL : tli_pkg::ST_OK;
    else ctl_in.status = empty ? tli_pkg::ST_EMPTY : tli_pkg::ST_OK;
  end

  tli_scale #(.CW(CW)) u_scale (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_i(ctl_in), .sample_i(in_sample), .cnt_i(cnt),
    .ratio_i(ratio_r), .offset_i(offset_r),
    .ctl_o(ctl_s), .v_o(v_s), .cnt_o(cnt_s)
  );

  tli_table #(.MAX_POINTS(MAX_POINTS), .CW(CW), .IW(IW)) u_table (
    .clk(clk), .rst_n(rst_n), .en(en),
    .wr_en(wr_en), .wr_x(in_point_in), .wr_y(in_point_out),
    .cnt_o(cnt), .full_o(full),
    .ctl_i(ctl_s), .v_i(v_s), .cnt_i(cnt_s),
    .ctl_o(ctl_t2), .dir_o(dir_t), .v_o(v_t),
    .xa_o(xa), .xb_o(xb), .ya_o(ya), .yb_o(yb)
  );

  tli_lerp u_lerp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_i(ctl_t2), .dir_i(dir_t), .v_i(v_t),
    .xa_i(xa), .xb_i(xb), .ya_i(ya), .yb_i(yb),
    .ctl_o(ctl_out), .res_o(res)
  );

  assign out_valid        = ctl_out.valid;
  assign out_result_value = res;
  assign out_status       = ctl_out.status;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a stalled result");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CW'(MAX_POINTS))
    else $error("point count beyond table size");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != tli_pkg::ST_OK) |-> (out_result_value == '0))
    else $error("flagged beat with nonzero result");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_opcode == tli_pkg::OP_LOAD && full) |=> (cnt == CW'(MAX_POINTS)))
    else $error("load into full table changed the count");

endmodule
